// ===== sv/cvmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_pkg
// Shared types and constants of the circular velocity mass histogram.
// ----------------------------------------------------------------------------
package cvmh_pkg;

  localparam int FIELD_W    = 20;  // packed coordinate field, velocity limits, bin center
  localparam int UNIT_W     = 20;  // unit axis component, signed, 18 fraction bits
  localparam int UNIT_FRAC  = 18;
  localparam int AXIS_SHIFT = 40;  // scale of the axis norm before the square root
  localparam int UNIT_SHIFT = 38;  // scale of an axis component before the division
  localparam int VEL_LOG    = 40;  // velocity clamp is two to this power
  localparam int MASS_IN_W  = 24;
  localparam int MASS_W     = 48;
  localparam int BW_W       = 24;
  localparam int BIN_IDX_W  = 6;
  localparam int BINS_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEN_POS = 3'd0,
    CFG_CEN_VEL = 3'd1,
    CFG_AXIS    = 3'd2,
    CFG_VMIN    = 3'd3,
    CFG_VMAX    = 3'd4,
    CFG_BINS    = 3'd5
  } cfg_reg_e;

endpackage

// ===== sv/cvmh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh interfaces
// Valid/ready channels for particles, histogram bins and register writes.
// ----------------------------------------------------------------------------
interface cvmh_part_if #(parameter int COORD_WIDTH = 20);
  logic                               valid;
  logic                               ready;
  logic signed [COORD_WIDTH-1:0]      pos_x, pos_y, pos_z;
  logic signed [COORD_WIDTH-1:0]      vel_x, vel_y, vel_z;
  logic [cvmh_pkg::MASS_IN_W-1:0]     particle_mass;
  logic                               last_particle;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  particle_mass, last_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  particle_mass, last_particle, output ready);
endinterface

interface cvmh_bin_if;
  logic                               valid;
  logic                               ready;
  logic [cvmh_pkg::BIN_IDX_W-1:0]     bin_index;
  logic signed [cvmh_pkg::FIELD_W-1:0] bin_center;
  logic [cvmh_pkg::MASS_W-1:0]        bin_mass;
  logic                               last_bin;

  modport source (output valid, bin_index, bin_center, bin_mass, last_bin, input ready);
  modport sink   (input valid, bin_index, bin_center, bin_mass, last_bin, output ready);
endinterface

interface cvmh_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cvmh_pkg::CFG_IDX_W-1:0]     index;
  logic [cvmh_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/cvmh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/cvmh_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cvmh_sqrt #(
  parameter int RW = 84
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RW-1:0]   rad_i,
  output logic            done_o,
  output logic [RW/2-1:0] root_o
);
  localparam int RTW  = RW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   rad_q;
  logic [RTW+1:0]  rem_q;
  logic [RTW-1:0]  root_q;
  logic [RTW+3:0]  rem2, trial, rem_n;
  logic            ge;

  always_comb begin
    rem2  = {rem_q, rad_q[RW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem2 >= trial;
    rem_n = ge ? rem2 - trial : rem2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(RTW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_n[RTW+1:0];
      root_q <= {root_q[RTW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== sv/cvmh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvmh_div #(
  parameter int NW = 66,
  parameter int DW = 42
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, dvs_q;
  logic [DW:0]     r2, r_n;
  logic            ge;

  always_comb begin
    r2  = {rem_q, quo_q[NW-1]};
    ge  = r2 >= {1'b0, dvs_q};
    r_n = ge ? r2 - {1'b0, dvs_q} : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= r_n[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ===== sv/circular_velocity_mass_histogram_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_velocity_mass_histogram_core
// Bins particle mass by circular velocity about a configured axis and reads
// the histogram out on the last particle.
// ----------------------------------------------------------------------------
//  Channel  Dir  Carries                                   Accepted when
//  cfg_i    in   index, data (register write)              valid & ready
//  part_i   in   position, velocity, mass, last flag       valid & ready
//  bin_o    out  bin index, center, mass, last-bin flag    valid & ready
//
// One particle is processed at a time. For each particle the
// shared multiplier runs 27 partial products in sequence, the square root
// unit produces one bit per cycle and the divider one quotient bit per cycle,
// for the velocity and again for the bin number. A readout then steps through
// S_RRD, S_RLD and S_ROUT for each bin, holding in S_ROUT while the output
// stalls. An axis write runs the norm square root and three divisions; a range
// or bin count write runs at most one division for the bin width.
// Reset clears control state and the bin valid flags, so the histogram
// needs no clearing pass. Particles and register writes wait while busy.
// ----------------------------------------------------------------------------
module circular_velocity_mass_histogram_core #(
  parameter int MAX_BINS    = 64,
  parameter int COORD_WIDTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cvmh_cfg_if.sink    cfg_i,
  cvmh_part_if.sink   part_i,
  cvmh_bin_if.source  bin_o
);
  import cvmh_pkg::*;

  // Differences against the center are one bit wider than the wider operand.
  localparam int DW  = ((COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W) + 1;
  localparam int SPW = 2 * DW + 1;            // spin component
  localparam int CUW = DW + UNIT_W + 1;       // component of d x u
  localparam int MULW = DW + 1;               // multiplier operand
  localparam int AXW = SPW + UNIT_W + 2;      // axial product sum
  localparam int NW  = AXW + 1;               // divider dividend
  localparam int SQW = 2 * CUW;               // squared distance
  localparam int RTW = CUW;                   // its root
  localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int VW  = VEL_LOG + 2;           // clamped velocity, signed
  localparam int DDW = VW + 1;                // velocity above the minimum

  localparam logic [4:0] S_IDLE = 5'd0,  S_AXM  = 5'd1,  S_AXS  = 5'd2,
                         S_AXSW = 5'd3,  S_AXD  = 5'd4,  S_AXDW = 5'd5,
                         S_WDD  = 5'd6,  S_WDDW = 5'd7,  S_PM   = 5'd8,
                         S_PS   = 5'd9,  S_PSW  = 5'd10, S_PVD  = 5'd11,
                         S_PVDW = 5'd12, S_PBD  = 5'd13, S_PBDW = 5'd14,
                         S_PRD  = 5'd15, S_PWR  = 5'd16, S_END  = 5'd17,
                         S_RRD  = 5'd18, S_RLD  = 5'd19, S_ROUT = 5'd20;

  localparam logic [VEL_LOG:0]   VEL_CLAMP = {1'b1, {VEL_LOG{1'b0}}};
  localparam logic [UNIT_FRAC:0] UNIT_ONE  = {1'b1, {UNIT_FRAC{1'b0}}};

  logic [4:0] state_q;

  // Configuration registers and derived state.
  logic [CFG_DATA_W-1:0]      cpos_q, cvel_q, axis_q;
  logic signed [FIELD_W-1:0]  vmin_q, vmax_q;
  logic [BINS_W-1:0]          bins_q, nb;
  logic signed [UNIT_W-1:0]   unit_q [3];
  logic [BW_W-1:0]            bw_q;

  // Particle working registers.
  logic signed [DW-1:0]       dp_q [3], dv_q [3];
  logic [MASS_IN_W-1:0]       mass_q;
  logic                       last_q;
  logic [4:0]                 mc_q, am;
  logic signed [MULW-1:0]     ma, mb;
  logic signed [2*MULW-1:0]   prod_q;
  logic signed [SPW-1:0]      spin_q [3];
  logic signed [CUW-1:0]      cu_q [3];
  logic signed [MULW-1:0]     spin_hi [3], spin_lo [3], cu_hi [3], cu_lo [3];
  logic signed [AXW-1:0]      axial_q;
  logic [SQW-1:0]             perp2_q;
  logic [RTW-1:0]             n_q;
  logic [1:0]                 ai_q;
  logic [DDW-2:0]             d_q;
  logic [AW-1:0]              k_q;
  logic [BINS_W-1:0]          ro_q;

  // Output register.
  logic                       ovld_q, olast_q;
  logic [BIN_IDX_W-1:0]       oidx_q;
  logic signed [FIELD_W-1:0]  octr_q;
  logic [MASS_W-1:0]          omass_q;

  // Bin store: entries whose valid flag is clear read as zero.
  logic [MAX_BINS-1:0]        vld_q;
  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [MASS_W-1:0]          ram_wdata, ram_rdata;

  // Shared arithmetic units.
  logic                       sq_start, sq_done, dv_start, dv_done;
  logic [SQW-1:0]             sq_rad;
  logic [RTW-1:0]             sq_root;
  logic [NW-1:0]              dv_a, dv_quo;
  logic [RTW-1:0]             dv_b;

  logic signed [FIELD_W-1:0]  cp [3], cv [3], ax [3];
  logic                       cfg_fire, in_fire;
  logic [FIELD_W-1:0]         aabs;
  logic [FIELD_W:0]           span;
  logic [UNIT_FRAC:0]         uq;
  logic [VEL_LOG:0]           qm;
  logic signed [VW-1:0]       vel;
  logic signed [DDW-1:0]      dvel;
  logic [MASS_W-1:0]          old_mass;
  logic [MASS_W:0]            msum;
  logic [2*BINS_W+BW_W-1:0]   ctr_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cp[i] = cpos_q[FIELD_W*i +: FIELD_W];
      cv[i] = cvel_q[FIELD_W*i +: FIELD_W];
      ax[i] = axis_q[FIELD_W*i +: FIELD_W];
    end
  end

  // The spin and d x u components are too wide for the multiplier, so they
  // are split into a signed upper limb and an unsigned lower limb of DW bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      spin_hi[i] = MULW'($signed(spin_q[i][SPW-1:DW]));
      spin_lo[i] = MULW'({1'b0, spin_q[i][DW-1:0]});
      cu_hi[i]   = MULW'($signed(cu_q[i][CUW-1:DW]));
      cu_lo[i]   = MULW'({1'b0, cu_q[i][DW-1:0]});
    end
  end

  // A bin count of zero acts as one, any count above the store size as the size.
  always_comb begin
    if (bins_q == '0) begin
      nb = BINS_W'(1);
    end else if (bins_q > BINS_W'(MAX_BINS)) begin
      nb = BINS_W'(MAX_BINS);
    end else begin
      nb = bins_q;
    end
  end

  assign cfg_i.ready  = (state_q == S_IDLE);
  assign part_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_fire     = cfg_i.valid && cfg_i.ready;
  assign in_fire      = part_i.valid && part_i.ready;

  // Operand selection for the shared multiplier. Particle steps: six products
  // for the spin d x w, six for d x u, then the axial projection as two limb
  // products per component and the squares of d x u as three limb products
  // per component (upper squared, upper times lower, lower squared).
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_AXM) begin
      if (mc_q < 5'd3) begin
        ma = MULW'(ax[mc_q[1:0]]);
        mb = MULW'(ax[mc_q[1:0]]);
      end
    end else begin
      case (mc_q)
        5'd0:  begin ma = MULW'(dp_q[1]); mb = MULW'(dv_q[2]);   end
        5'd1:  begin ma = MULW'(dp_q[2]); mb = MULW'(dv_q[1]);   end
        5'd2:  begin ma = MULW'(dp_q[2]); mb = MULW'(dv_q[0]);   end
        5'd3:  begin ma = MULW'(dp_q[0]); mb = MULW'(dv_q[2]);   end
        5'd4:  begin ma = MULW'(dp_q[0]); mb = MULW'(dv_q[1]);   end
        5'd5:  begin ma = MULW'(dp_q[1]); mb = MULW'(dv_q[0]);   end
        5'd6:  begin ma = MULW'(dp_q[1]); mb = MULW'(unit_q[2]); end
        5'd7:  begin ma = MULW'(dp_q[2]); mb = MULW'(unit_q[1]); end
        5'd8:  begin ma = MULW'(dp_q[2]); mb = MULW'(unit_q[0]); end
        5'd9:  begin ma = MULW'(dp_q[0]); mb = MULW'(unit_q[2]); end
        5'd10: begin ma = MULW'(dp_q[0]); mb = MULW'(unit_q[1]); end
        5'd11: begin ma = MULW'(dp_q[1]); mb = MULW'(unit_q[0]); end
        5'd12: begin ma = spin_hi[0];     mb = MULW'(unit_q[0]); end
        5'd13: begin ma = spin_lo[0];     mb = MULW'(unit_q[0]); end
        5'd14: begin ma = spin_hi[1];     mb = MULW'(unit_q[1]); end
        5'd15: begin ma = spin_lo[1];     mb = MULW'(unit_q[1]); end
        5'd16: begin ma = spin_hi[2];     mb = MULW'(unit_q[2]); end
        5'd17: begin ma = spin_lo[2];     mb = MULW'(unit_q[2]); end
        5'd18: begin ma = cu_hi[0];       mb = cu_hi[0];         end
        5'd19: begin ma = cu_hi[0];       mb = cu_lo[0];         end
        5'd20: begin ma = cu_lo[0];       mb = cu_lo[0];         end
        5'd21: begin ma = cu_hi[1];       mb = cu_hi[1];         end
        5'd22: begin ma = cu_hi[1];       mb = cu_lo[1];         end
        5'd23: begin ma = cu_lo[1];       mb = cu_lo[1];         end
        5'd24: begin ma = cu_hi[2];       mb = cu_hi[2];         end
        5'd25: begin ma = cu_hi[2];       mb = cu_lo[2];         end
        5'd26: begin ma = cu_lo[2];       mb = cu_lo[2];         end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  assign am = mc_q - 5'd1;

  // Divider and square root operands, chosen by the launching state.
  always_comb begin
    aabs     = (ax[ai_q] < 0) ? FIELD_W'(-ax[ai_q]) : FIELD_W'(ax[ai_q]);
    span     = (FIELD_W + 1)'(vmax_q) - (FIELD_W + 1)'(vmin_q);
    sq_start = 1'b0;
    sq_rad   = perp2_q;
    dv_start = 1'b0;
    dv_a     = '0;
    dv_b     = n_q;
    unique case (state_q)
      S_AXS: begin
        sq_start = (perp2_q != '0);
        sq_rad   = perp2_q << AXIS_SHIFT;
      end
      S_PS: sq_start = 1'b1;
      S_AXD: begin
        dv_start = 1'b1;
        dv_a     = (NW'(aabs) << UNIT_SHIFT) + NW'(n_q >> 1);
      end
      S_WDD: begin
        dv_start = (vmax_q > vmin_q);
        dv_a     = NW'(span);
        dv_b     = RTW'(nb);
      end
      S_PVD: begin
        dv_start = (n_q != '0) && (bw_q != '0);
        // Negative values divide with rounding toward minus infinity.
        dv_a = axial_q[AXW-1] ? NW'(-(NW'(axial_q))) + NW'(n_q - 1'b1) : NW'(axial_q);
      end
      S_PBD: begin
        dv_start = 1'b1;
        dv_a     = NW'(d_q);
        dv_b     = RTW'(bw_q);
      end
      default: ;
    endcase
  end

  // Quotient post-processing for the axis and the velocity, plus the bin mass sum and center.
  always_comb begin
    uq       = (dv_quo > NW'(UNIT_ONE)) ? UNIT_ONE : dv_quo[UNIT_FRAC:0];
    qm       = (dv_quo > NW'(VEL_CLAMP)) ? VEL_CLAMP : dv_quo[VEL_LOG:0];
    vel      = axial_q[AXW-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    dvel     = DDW'(vel) - DDW'(vmin_q);
    old_mass = vld_q[k_q] ? ram_rdata : '0;
    msum     = {1'b0, old_mass} + (MASS_W + 1)'(mass_q);
    ram_wdata = msum[MASS_W] ? '1 : msum[MASS_W-1:0];
    ram_we    = (state_q == S_PWR);
    ram_raddr = (state_q == S_PRD) ? k_q : ro_q[AW-1:0];
    ctr_prod  = (2*BINS_W+BW_W)'({ro_q, 1'b1}) * (2*BINS_W+BW_W)'(bw_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cpos_q  <= '0;
      cvel_q  <= '0;
      axis_q  <= '0;
      vmin_q  <= '0;
      vmax_q  <= '0;
      bins_q  <= BINS_W'(MAX_BINS);
      for (int i = 0; i < 3; i++) unit_q[i] <= '0;
      bw_q    <= '0;
      vld_q   <= '0;
      ovld_q  <= 1'b0;
      mc_q    <= '0;
      ai_q    <= '0;
      ro_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_fire) begin
            case (cfg_i.index)
              CFG_CEN_POS: cpos_q <= cfg_i.data;
              CFG_CEN_VEL: cvel_q <= cfg_i.data;
              CFG_AXIS: begin
                axis_q  <= cfg_i.data;
                perp2_q <= '0;
                mc_q    <= '0;
                state_q <= S_AXM;
              end
              CFG_VMIN: begin
                vmin_q  <= cfg_i.data[FIELD_W-1:0];
                state_q <= S_WDD;
              end
              CFG_VMAX: begin
                vmax_q  <= cfg_i.data[FIELD_W-1:0];
                state_q <= S_WDD;
              end
              CFG_BINS: begin
                bins_q  <= cfg_i.data[BINS_W-1:0];
                state_q <= S_WDD;
              end
              default: ;
            endcase
          end else if (in_fire) begin
            dp_q[0] <= DW'(part_i.pos_x) - DW'(cp[0]);
            dp_q[1] <= DW'(part_i.pos_y) - DW'(cp[1]);
            dp_q[2] <= DW'(part_i.pos_z) - DW'(cp[2]);
            dv_q[0] <= DW'(part_i.vel_x) - DW'(cv[0]);
            dv_q[1] <= DW'(part_i.vel_y) - DW'(cv[1]);
            dv_q[2] <= DW'(part_i.vel_z) - DW'(cv[2]);
            mass_q  <= part_i.particle_mass;
            last_q  <= part_i.last_particle;
            axial_q <= '0;
            perp2_q <= '0;
            mc_q    <= '0;
            state_q <= S_PM;
          end
        end

        // Axis norm: sum of squares, square root, three scaled divisions.
        S_AXM: begin
          prod_q <= ma * mb;
          mc_q   <= mc_q + 5'd1;
          if (mc_q != '0) perp2_q <= perp2_q + SQW'(prod_q);
          if (mc_q == 5'd3) state_q <= S_AXS;
        end
        S_AXS: begin
          if (perp2_q == '0) begin
            for (int i = 0; i < 3; i++) unit_q[i] <= '0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_AXSW;
          end
        end
        S_AXSW: begin
          if (sq_done) begin
            n_q     <= sq_root;
            ai_q    <= '0;
            state_q <= S_AXD;
          end
        end
        S_AXD: state_q <= S_AXDW;
        S_AXDW: begin
          if (dv_done) begin
            unit_q[ai_q] <= (ax[ai_q] < 0) ? -UNIT_W'(uq) : UNIT_W'(uq);
            ai_q         <= ai_q + 2'd1;
            state_q      <= (ai_q == 2'd2) ? S_IDLE : S_AXD;
          end
        end

        // Bin width from the velocity range.
        S_WDD: begin
          if (vmax_q > vmin_q) begin
            state_q <= S_WDDW;
          end else begin
            bw_q    <= '0;
            state_q <= S_IDLE;
          end
        end
        S_WDDW: begin
          if (dv_done) begin
            bw_q    <= dv_quo[BW_W-1:0];
            state_q <= S_IDLE;
          end
        end

        // Particle products, accumulated from the product register in the cycle after each multiply.
        // Upper-limb products are weighted by their limb position.
        S_PM: begin
          prod_q <= ma * mb;
          mc_q   <= mc_q + 5'd1;
          if (mc_q != '0) begin
            case (am) inside
              5'd0:  spin_q[0] <= SPW'(prod_q);
              5'd1:  spin_q[0] <= spin_q[0] - SPW'(prod_q);
              5'd2:  spin_q[1] <= SPW'(prod_q);
              5'd3:  spin_q[1] <= spin_q[1] - SPW'(prod_q);
              5'd4:  spin_q[2] <= SPW'(prod_q);
              5'd5:  spin_q[2] <= spin_q[2] - SPW'(prod_q);
              5'd6:  cu_q[0]   <= CUW'(prod_q);
              5'd7:  cu_q[0]   <= cu_q[0] - CUW'(prod_q);
              5'd8:  cu_q[1]   <= CUW'(prod_q);
              5'd9:  cu_q[1]   <= cu_q[1] - CUW'(prod_q);
              5'd10: cu_q[2]   <= CUW'(prod_q);
              5'd11: cu_q[2]   <= cu_q[2] - CUW'(prod_q);
              5'd12, 5'd14, 5'd16: axial_q <= axial_q + (AXW'(prod_q) << DW);
              5'd13, 5'd15, 5'd17: axial_q <= axial_q + AXW'(prod_q);
              5'd18, 5'd21, 5'd24: perp2_q <= perp2_q + (SQW'(prod_q) << (2 * DW));
              5'd19, 5'd22, 5'd25: perp2_q <= perp2_q + (SQW'(prod_q) << (DW + 1));
              default: perp2_q <= perp2_q + SQW'(prod_q);
            endcase
          end
          if (mc_q == 5'd27) state_q <= S_PS;
        end
        S_PS: state_q <= S_PSW;
        S_PSW: begin
          if (sq_done) begin
            n_q     <= sq_root;
            state_q <= S_PVD;
          end
        end
        // On the axis, or with a zero bin width, the particle is dropped.
        S_PVD: state_q <= ((n_q != '0) && (bw_q != '0)) ? S_PVDW : S_END;
        S_PVDW: begin
          if (dv_done) begin
            d_q     <= dvel[DDW-2:0];
            state_q <= dvel[DDW-1] ? S_END : S_PBD;
          end
        end
        S_PBD: state_q <= S_PBDW;
        S_PBDW: begin
          if (dv_done) begin
            k_q     <= dv_quo[AW-1:0];
            state_q <= (dv_quo < NW'(nb)) ? S_PRD : S_END;
          end
        end
        S_PRD: state_q <= S_PWR;
        S_PWR: begin
          vld_q[k_q] <= 1'b1;
          state_q    <= S_END;
        end
        S_END: begin
          ro_q    <= '0;
          state_q <= last_q ? S_RRD : S_IDLE;
        end

        // Readout: one bin per output item, then the store is emptied.
        S_RRD: state_q <= S_RLD;
        S_RLD: begin
          ovld_q  <= 1'b1;
          oidx_q  <= BIN_IDX_W'(ro_q);
          octr_q  <= vmin_q + FIELD_W'(ctr_prod >> 1);
          omass_q <= vld_q[ro_q[AW-1:0]] ? ram_rdata : '0;
          olast_q <= (ro_q + 1'b1 == nb);
          state_q <= S_ROUT;
        end
        S_ROUT: begin
          if (bin_o.ready) begin
            ovld_q <= 1'b0;
            ro_q   <= ro_q + 1'b1;
            if (olast_q) begin
              vld_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign bin_o.valid      = ovld_q;
  assign bin_o.bin_index  = oidx_q;
  assign bin_o.bin_center = octr_q;
  assign bin_o.bin_mass   = omass_q;
  assign bin_o.last_bin   = olast_q;

  cvmh_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BINS)) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (k_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cvmh_sqrt #(.RW(SQW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  cvmh_div #(.NW(NW), .DW(RTW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_a),
    .divisor_i  (dv_b),
    .done_o     (dv_done),
    .quot_o     (dv_quo)
  );
endmodule

// ===== sv/cvmh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_checker
// Port-level checks of the histogram core, bound to the top level.
// ----------------------------------------------------------------------------
module cvmh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic cfg_valid,
  input logic cfg_ready
);
  // A result item stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // No particle is taken during a readout.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(in_valid && in_ready))
    else $error("particle accepted during readout");

  // The final bin ends the readout.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result item after the final bin");

  // A register write never starts a readout.
  a_cfg_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready |=> !out_valid)
    else $error("result item after a register write");
endmodule

bind circular_velocity_mass_histogram_core cvmh_checker u_cvmh_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (part_i.valid),
  .in_ready  (part_i.ready),
  .out_valid (bin_o.valid),
  .out_ready (bin_o.ready),
  .out_last  (bin_o.last_bin),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

// ===== verif/cvmh_hist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmh_hist_checker
// Watches the register, particle and bin channels of the histogram core,
// keeps its own copy of the histogram and compares every bin it reports.
// ----------------------------------------------------------------------------
module cvmh_hist_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  cvmh_cfg_if   cfg,
  cvmh_part_if  part,
  cvmh_bin_if   bins_if,
  output int    mismatches,
  output int    outstanding
);
  import cvmh_pkg::*;

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] idx;
    logic [FIELD_W-1:0]   center;
    logic [MASS_W-1:0]    mass;
    logic                 last;
  } bin_rec_t;

  localparam logic [MASS_W:0] MASS_TOP = {1'b0, {MASS_W{1'b1}}};
  localparam longint VEL_LIMIT = longint'(1) <<< VEL_LOG;

  bin_rec_t             readout_q[$];
  logic [59:0]          cen_pos, cen_vel, axis_raw;
  logic [FIELD_W-1:0]   vmin_reg, vmax_reg;
  logic [BINS_W-1:0]    bins_reg;
  logic [MASS_W-1:0]    mass_store[64];
  longint               unit_vec[3];
  longint               bin_step;

  function automatic logic [63:0] isqrt(logic [127:0] q);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int b = 53; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= q) r = t;
    end
    return r;
  endfunction

  function automatic longint fld(logic [59:0] r, int k);
    return longint'($signed(r[FIELD_W*k +: FIELD_W]));
  endfunction

  function automatic longint live_bins();
    if (bins_reg == 0) return 1;
    if (bins_reg > 64) return 64;
    return longint'(bins_reg);
  endfunction

  function automatic void refresh_step();
    longint lo;
    longint hi;
    lo = longint'($signed(vmin_reg));
    hi = longint'($signed(vmax_reg));
    bin_step = (hi > lo) ? (hi - lo) / live_bins() : 0;
  endfunction

  // The raw axis is scaled to a unit vector with 18 fraction bits, rounding
  // each component half away from zero.
  function automatic void normalize_axis();
    longint      a[3];
    logic [63:0] sum;
    logic [63:0] norm;
    logic [63:0] mag;
    logic [63:0] q;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = fld(axis_raw, i);
      sum += a[i] * a[i];
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) unit_vec[i] = 0;
      return;
    end
    norm = isqrt({64'd0, sum} << AXIS_SHIFT);
    for (int i = 0; i < 3; i++) begin
      mag = (a[i] < 0) ? -a[i] : a[i];
      q = ((mag << UNIT_SHIFT) + norm / 2) / norm;
      if (q > (64'd1 << UNIT_FRAC)) q = 64'd1 << UNIT_FRAC;
      unit_vec[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void clear_all();
    cen_pos  = '0;
    cen_vel  = '0;
    axis_raw = '0;
    vmin_reg = '0;
    vmax_reg = '0;
    bins_reg = 7'd64;
    bin_step = 0;
    for (int i = 0; i < 64; i++) mass_store[i] = '0;
    for (int i = 0; i < 3; i++) unit_vec[i] = 0;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CEN_POS: cen_pos = data;
      CFG_CEN_VEL: cen_vel = data;
      CFG_AXIS: begin
        axis_raw = data;
        normalize_axis();
      end
      CFG_VMIN: begin
        vmin_reg = data[FIELD_W-1:0];
        refresh_step();
      end
      CFG_VMAX: begin
        vmax_reg = data[FIELD_W-1:0];
        refresh_step();
      end
      CFG_BINS: begin
        bins_reg = data[BINS_W-1:0];
        refresh_step();
      end
      default: ;
    endcase
  endfunction

  // Circular velocity is the axial spin divided by the distance from the
  // axis, rounded toward minus infinity.
  function automatic void accumulate(longint p[3], longint w[3], logic [MASS_IN_W-1:0] m);
    longint          dp[3];
    longint          dv[3];
    longint          cu[3];
    longint          spin;
    acc_t            axial;
    acc_t            perp2;
    logic [127:0]    mag;
    logic [127:0]    q;
    logic [63:0]     n;
    longint          vel;
    longint          d;
    longint          k;
    logic [MASS_W:0] s;
    int              j;
    int              l;
    axial = '0;
    perp2 = '0;
    for (int i = 0; i < 3; i++) begin
      dp[i] = p[i] - fld(cen_pos, i);
      dv[i] = w[i] - fld(cen_vel, i);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      l = (i + 2) % 3;
      spin  = dp[j] * dv[l] - dp[l] * dv[j];
      cu[i] = dp[j] * unit_vec[l] - dp[l] * unit_vec[j];
      axial += acc_t'(spin) * acc_t'(unit_vec[i]);
      perp2 += acc_t'(cu[i]) * acc_t'(cu[i]);
    end
    n = isqrt(perp2);
    if (n == 0 || bin_step == 0) return;
    mag = (axial < 0) ? -axial + n - 1 : axial;
    q = mag / {64'd0, n};
    vel = (q > VEL_LIMIT) ? VEL_LIMIT : longint'(q);
    if (axial < 0) vel = -vel;
    d = vel - longint'($signed(vmin_reg));
    if (d < 0) return;
    k = d / bin_step;
    if (k >= live_bins()) return;
    s = {1'b0, mass_store[k]} + m;
    mass_store[k] = (s > MASS_TOP) ? MASS_TOP[MASS_W-1:0] : s[MASS_W-1:0];
  endfunction

  function automatic void queue_readout();
    bin_rec_t r;
    longint   nb;
    longint   ctr;
    nb = live_bins();
    for (int i = 0; i < nb; i++) begin
      ctr = longint'($signed(vmin_reg)) + ((2 * i + 1) * bin_step) / 2;
      r.idx    = i[BIN_IDX_W-1:0];
      r.center = ctr[FIELD_W-1:0];
      r.mass   = mass_store[i];
      r.last   = (i + 1 == nb);
      readout_q.push_back(r);
    end
    for (int i = 0; i < 64; i++) mass_store[i] = '0;
  endfunction

  function automatic void compare_bin();
    bin_rec_t want;
    bin_rec_t got;
    got = '{bins_if.bin_index, bins_if.bin_center, bins_if.bin_mass, bins_if.last_bin};
    if (readout_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected bin: index %0d center %0d mass %0d last %0b",
                 got.idx, $signed(got.center), got.mass, got.last);
      return;
    end
    want = readout_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("bin mismatch: expected idx %0d ctr %0d mass %0d last %0b, got %0d %0d %0d %0b",
                 want.idx, $signed(want.center), want.mass, want.last,
                 got.idx, $signed(got.center), got.mass, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      readout_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
      if (part.valid && part.ready) begin
        accumulate('{longint'(part.pos_x), longint'(part.pos_y), longint'(part.pos_z)},
                   '{longint'(part.vel_x), longint'(part.vel_y), longint'(part.vel_z)},
                   part.particle_mass);
        if (part.last_particle) queue_readout();
      end
      if (bins_if.valid && bins_if.ready) compare_bin();
      outstanding = readout_q.size();
    end
  end

endmodule

// ===== verif/circular_velocity_mass_histogram_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_velocity_mass_histogram_core_test
// Drives particles and register writes into the histogram core under random
// idling on both sides; a checker beside the core predicts every bin.
// ----------------------------------------------------------------------------
module circular_velocity_mass_histogram_core_test;
  import cvmh_pkg::*;

  // Register indexes the core does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [19:0] C_MAX = 20'h7FFFF;
  localparam logic [19:0] C_MIN = 20'h80000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches;
  int   outstanding;
  int   idle_pct = 23;

  cvmh_cfg_if  cfg_bus ();
  cvmh_part_if #(.COORD_WIDTH(20)) part_bus ();
  cvmh_bin_if  bin_bus ();

  always #6 clk_i = ~clk_i;

  circular_velocity_mass_histogram_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .part_i (part_bus),
    .bin_o  (bin_bus)
  );

  cvmh_hist_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg_bus),
    .part        (part_bus),
    .bins_if     (bin_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The bin receiver stalls at random, at the same rate as the sender idles.
  initial bin_bus.ready = 1'b0;
  always @(negedge clk_i) begin
    bin_bus.ready <= ($urandom_range(99) >= idle_pct);
  end

  // A random signed value spanning lg bits, sign-extended to a field.
  function automatic logic [19:0] rand_coord(int lg);
    int v;
    v = int'($urandom_range((1 << lg) - 1)) - (1 << (lg - 1));
    return v[19:0];
  endfunction

  function automatic logic [59:0] pack3(logic [19:0] x, logic [19:0] y, logic [19:0] z);
    return {z, y, x};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offers one particle, idling first at random; valid stays high afterwards
  // so that back-to-back items stream without a gap.
  task automatic send_particle(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                               logic [19:0] vx, logic [19:0] vy, logic [19:0] vz,
                               logic [23:0] m, logic lastp);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      part_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    part_bus.valid         <= 1'b1;
    part_bus.pos_x         <= px;
    part_bus.pos_y         <= py;
    part_bus.pos_z         <= pz;
    part_bus.vel_x         <= vx;
    part_bus.vel_y         <= vy;
    part_bus.vel_z         <= vz;
    part_bus.particle_mass <= m;
    part_bus.last_particle <= lastp;
    @(posedge clk_i);
    while (!part_bus.ready) @(posedge clk_i);
  endtask

  // Waits until every predicted bin has come back, then idles so that the core
  // is back in its idle state before anything else changes.
  task automatic drain();
    @(negedge clk_i);
    part_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  // Mostly small coordinates so that velocities fall into the bins; now and
  // then a full-range value to toggle every bit of every field.
  task automatic rand_particle(int lgv, logic lastp);
    int lgp;
    int lgw;
    lgp = ($urandom_range(3) == 0) ? 20 : $urandom_range(6, 12);
    lgw = ($urandom_range(5) == 0) ? 20 : lgv;
    send_particle(rand_coord(lgp), rand_coord(lgp), rand_coord(lgp),
                  rand_coord(lgw), rand_coord(lgw), rand_coord(lgw),
                  ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom()), lastp);
  endtask

  task automatic rand_config(int lgv);
    logic [19:0] lo;
    logic [19:0] hi;
    int          pick;
    write_reg(CFG_CEN_POS, pack3(rand_coord(9), rand_coord(9), rand_coord(9)));
    write_reg(CFG_CEN_VEL, pack3(rand_coord(8), rand_coord(8), rand_coord(8)));
    if ($urandom_range(2) == 0)
      write_reg(CFG_AXIS, 60'($urandom()) | (60'($urandom()) << 30));
    else
      write_reg(CFG_AXIS, pack3(rand_coord(4), rand_coord(4), rand_coord(4)) | 60'd1);
    lo = -20'($urandom_range(1 << (lgv - 2), 1 << lgv));
    hi = 20'($urandom_range(1 << (lgv - 2), 1 << lgv));
    write_reg(CFG_VMIN, {$urandom(), 8'd0} | 60'(lo));
    write_reg(CFG_VMAX, 60'(hi));
    pick = $urandom_range(9);
    write_reg(CFG_BINS, (pick == 0) ? 60'd1 : (pick == 1) ? 60'd64 : 60'($urandom_range(2, 63)));
  endtask

  task automatic rand_phase(int count, int lgv);
    for (int i = 0; i < count; i++) begin
      rand_particle(lgv, (i == count - 1) || ($urandom_range(7) == 0));
      // Hold the sender off once until the histogram has been read out.
      if (i == count / 2 && $urandom_range(1) == 0) drain();
    end
    drain();
  endtask

  initial begin
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_CEN_POS;
    cfg_bus.data   = '0;
    part_bus.valid = 1'b0;
    part_bus.pos_x = '0;
    part_bus.pos_y = '0;
    part_bus.pos_z = '0;
    part_bus.vel_x = '0;
    part_bus.vel_y = '0;
    part_bus.vel_z = '0;
    part_bus.particle_mass = '0;
    part_bus.last_particle = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the reset axis of zero every particle is dropped, and the reset
    // range gives zero-width bins all centered on the minimum.
    send_particle(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 24'hFFFFFF, 1'b0);
    send_particle(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 24'h000001, 1'b1);
    drain();

    // Axis along z over the widest range.
    write_reg(CFG_AXIS, pack3(20'd0, 20'd0, 20'd1024));
    write_reg(CFG_VMIN, 60'(C_MIN));
    write_reg(CFG_VMAX, 60'(C_MAX));
    write_reg(CFG_BINS, 60'd64);
    send_particle(20'd256, 20'd0, 20'd0, 20'd0, 20'd512, 20'd0, 24'd100, 1'b0);
    send_particle(20'd256, 20'd0, 20'd0, 20'd0, -20'd512, 20'd0, 24'd7, 1'b0);
    // A particle on the axis has no distance from it and is dropped.
    send_particle(20'd0, 20'd0, 20'd300, 20'd40, 20'd40, 20'd0, 24'd55, 1'b0);
    send_particle(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 24'hFFFFFF, 1'b0);
    send_particle(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 24'hFFFFFF, 1'b0);
    send_particle(C_MAX, C_MAX, 20'd0, C_MIN, C_MAX, 20'd0, 24'd0, 1'b1);
    drain();

    // A bin count of zero acts as one; a count above the limit acts as the limit.
    write_reg(CFG_CEN_POS, pack3(20'd16, -20'd16, 20'd0));
    write_reg(CFG_CEN_VEL, pack3(-20'd8, 20'd8, 20'd0));
    write_reg(CFG_BINS, 60'd0);
    send_particle(20'd300, 20'd20, 20'd5, 20'd10, 20'd400, 20'd3, 24'd9, 1'b1);
    drain();
    write_reg(CFG_BINS, 60'd127);
    write_reg(CFG_VMIN, 60'(-20'd2048));
    write_reg(CFG_VMAX, 60'd2048);
    send_particle(20'd300, 20'd20, 20'd5, 20'd10, 20'd400, 20'd3, 24'd9, 1'b0);
    send_particle(-20'd200, 20'd90, 20'd5, 20'd300, 20'd10, 20'd3, 24'd21, 1'b1);
    drain();

    // An empty range, then one narrower than the bin count: zero bin width.
    write_reg(CFG_VMAX, 60'(-20'd4096));
    send_particle(20'd300, 20'd20, 20'd5, 20'd10, 20'd400, 20'd3, 24'd9, 1'b1);
    drain();
    write_reg(CFG_VMAX, 60'(-20'd2048 + 20'd40));
    write_reg(CFG_SPARE_A, {60{1'b1}});
    write_reg(CFG_SPARE_B, 60'd3);
    send_particle(20'd300, 20'd20, 20'd5, 20'd10, 20'd400, 20'd3, 24'd9, 1'b1);
    drain();

    // Random phases, one of them with no idling on either side.
    for (int ph = 0; ph < 10; ph++) begin
      idle_pct = (ph == 4) ? 0 : 23;
      rand_config((ph % 3 == 2) ? 18 : 12);
      rand_phase(15, (ph % 3 == 2) ? 18 : 12);
    end
    idle_pct = 23;

    while (outstanding != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
